// File: hw/rtl/nps_pkg.sv
// Shared types, widths and result codes of the priority scheduler.
package nps_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ID_W = 16;
	localparam int TIME_W = 16;
	localparam int PRIO_W = 8;
	localparam int KIND_W = 3;

	localparam logic [KIND_W-1:0] K_ADDED    = 3'd0;
	localparam logic [KIND_W-1:0] K_REJECTED = 3'd1;
	localparam logic [KIND_W-1:0] K_STARTED  = 3'd2;
	localparam logic [KIND_W-1:0] K_RUNNING  = 3'd3;
	localparam logic [KIND_W-1:0] K_FINISHED = 3'd4;
	localparam logic [KIND_W-1:0] K_IDLE     = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] run;
		logic [PRIO_W-1:0] prio;
	} entry_t;

endpackage

// File: hw/rtl/nps_table.sv
// Ready table memory: one write port, one read port with registered read data.
module nps_table #(
	parameter int DEPTH = nps_pkg::TABLE_DEPTH,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  nps_pkg::entry_t wdata,
	input  logic [AW-1:0]  raddr,
	output nps_pkg::entry_t rdata
);

	nps_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/nonpreemptive_priority_scheduler.sv
// Add or tick of a running process: the first result is valid in the cycle after the request.
// Tick that starts a process: the N stored entries are scanned, then shifted down
// (one table read per cycle for the minimum scan, then one per moved entry).
// One transaction at a time; a second result follows once the first is taken.
// Reset (arst_n low) empties the table and stops the running process at once.
module nonpreemptive_priority_scheduler #(
	parameter int TABLE_DEPTH = nps_pkg::TABLE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [nps_pkg::ID_W-1:0]     proc_id,
	input  logic [nps_pkg::TIME_W-1:0]   run_time,
	input  logic [nps_pkg::PRIO_W-1:0]   prio,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [nps_pkg::KIND_W-1:0]   kind,
	output logic [nps_pkg::ID_W-1:0]     out_id,
	output logic [nps_pkg::PRIO_W-1:0]   out_prio,
	output logic [nps_pkg::TIME_W-1:0]   remaining,
	output logic                         last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic          rv_s1;
	logic [AW-1:0] ri_s1;
	logic [AW-1:0] best_idx_q;
	nps_pkg::entry_t best_q;

	logic                        busy_q;
	logic [nps_pkg::ID_W-1:0]    cur_id_q;
	logic [nps_pkg::PRIO_W-1:0]  cur_prio_q;
	logic [nps_pkg::TIME_W-1:0]  cur_left_q;

	logic [nps_pkg::KIND_W-1:0]  kind_q;
	logic [nps_pkg::ID_W-1:0]    id_q;
	logic [nps_pkg::PRIO_W-1:0]  prio_q;
	logic [nps_pkg::TIME_W-1:0]  rem_q;
	logic                        last_q;
	logic                        two_q;

	logic            we;
	logic [AW-1:0]   waddr;
	nps_pkg::entry_t wdata;
	nps_pkg::entry_t rdata;
	logic            in_acc;
	logic            out_acc;
	logic            issue;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign out_acc   = out_valid && !out_stall;
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (ptr_q < count_q);

	assign kind      = kind_q;
	assign out_id    = id_q;
	assign out_prio  = prio_q;
	assign remaining = rem_q;
	assign last      = last_q;

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = rdata;
		if (in_acc && !op && (count_q < FULL)) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = '{id: proc_id, run: run_time, prio: prio};
		end else if ((state_q == ST_SHIFT) && rv_s1) begin
			we    = 1'b1;
			waddr = ri_s1 - AW'(1);
			wdata = rdata;
		end
	end

	nps_table #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			rv_s1      <= 1'b0;
			ri_s1      <= '0;
			best_idx_q <= '0;
			best_q     <= '0;
			busy_q     <= 1'b0;
			cur_id_q   <= '0;
			cur_prio_q <= '0;
			cur_left_q <= '0;
			kind_q     <= '0;
			id_q       <= '0;
			prio_q     <= '0;
			rem_q      <= '0;
			last_q     <= 1'b0;
			two_q      <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (issue) begin
				ri_s1 <= ptr_q[AW-1:0];
				ptr_q <= ptr_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						two_q <= 1'b0;
						if (!op) begin
							id_q    <= proc_id;
							prio_q  <= prio;
							rem_q   <= run_time;
							last_q  <= 1'b1;
							state_q <= ST_OUT;
							if (count_q < FULL) begin
								kind_q  <= nps_pkg::K_ADDED;
								count_q <= count_q + CW'(1);
							end else begin
								kind_q <= nps_pkg::K_REJECTED;
							end
						end else if (busy_q) begin
							id_q    <= cur_id_q;
							prio_q  <= cur_prio_q;
							state_q <= ST_OUT;
							if (cur_left_q == '0) begin
								kind_q <= nps_pkg::K_FINISHED;
								rem_q  <= '0;
								last_q <= 1'b1;
								busy_q <= 1'b0;
							end else begin
								kind_q     <= nps_pkg::K_RUNNING;
								rem_q      <= cur_left_q;
								cur_left_q <= cur_left_q - nps_pkg::TIME_W'(1);
								if (cur_left_q == nps_pkg::TIME_W'(1)) begin
									last_q <= 1'b0;
									two_q  <= 1'b1;
									busy_q <= 1'b0;
								end else begin
									last_q <= 1'b1;
								end
							end
						end else if (count_q == '0) begin
							kind_q  <= nps_pkg::K_IDLE;
							id_q    <= '0;
							prio_q  <= '0;
							rem_q   <= '0;
							last_q  <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							ptr_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rv_s1) begin
						if ((ri_s1 == '0) || (rdata.prio < best_q.prio)) begin
							best_q     <= rdata;
							best_idx_q <= ri_s1;
						end
					end else if (!issue) begin
						ptr_q   <= CW'(best_idx_q) + CW'(1);
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (!rv_s1 && !issue) begin
						count_q    <= count_q - CW'(1);
						cur_id_q   <= best_q.id;
						cur_prio_q <= best_q.prio;
						kind_q     <= nps_pkg::K_STARTED;
						id_q       <= best_q.id;
						prio_q     <= best_q.prio;
						rem_q      <= best_q.run;
						state_q    <= ST_OUT;
						if (best_q.run == '0) begin
							cur_left_q <= '0;
							last_q     <= 1'b0;
							two_q      <= 1'b1;
							busy_q     <= 1'b0;
						end else begin
							cur_left_q <= best_q.run - nps_pkg::TIME_W'(1);
							if (best_q.run == nps_pkg::TIME_W'(1)) begin
								last_q <= 1'b0;
								two_q  <= 1'b1;
								busy_q <= 1'b0;
							end else begin
								last_q <= 1'b1;
								busy_q <= 1'b1;
							end
						end
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (two_q) begin
							two_q  <= 1'b0;
							kind_q <= nps_pkg::K_FINISHED;
							rem_q  <= '0;
							last_q <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
